@@ hdl/damped_spring_step_assert.svh @@
// ----------------------------------------------------------------------------
// damped_spring_step assertion macros
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef DAMPED_SPRING_STEP_ASSERT_SVH
`define DAMPED_SPRING_STEP_ASSERT_SVH

// Same-cycle implication
`define DSS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("damped_spring_step: same-cycle check failed");

// Next-cycle implication
`define DSS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("damped_spring_step: next-cycle check failed");

`endif

@@ hdl/dss_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_pkg
// Shared widths, codes and constant-divider tables for the damped spring step.
// ----------------------------------------------------------------------------
package dss_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int WORD_W    = 32;
  localparam int DIFF_W    = WORD_W + 1;
  localparam int PROD_W    = 2 * WORD_W;
  localparam int IN_DATA_W = 2 * WORD_W;
  localparam int CFG_IDX_W = 2;

  // Step term magnitudes saturate at 2^40
  localparam int STEP_CAP_LOG = 40;
  localparam int MAG_W        = STEP_CAP_LOG + 1;
  localparam int NEXT_W       = STEP_CAP_LOG + 3;
  localparam logic [MAG_W-1:0] STEP_CAP = {1'b1, {STEP_CAP_LOG{1'b0}}};

  // Constant divider: one byte of quotient per cycle
  localparam int DIGIT_W     = 8;
  localparam int DIV_W       = STEP_CAP_LOG + WORD_W;
  localparam int DIGITS      = DIV_W / DIGIT_W;
  localparam int DIV_CNT_W   = $clog2(DIGITS + 1);
  localparam int REM_W       = 9;
  localparam int DIGIT_V_W   = REM_W + DIGIT_W;
  localparam int RECIP_W     = 22;
  localparam int RECIP_SHIFT = 25;
  localparam int QPROD_W     = DIGIT_V_W + RECIP_W;

  localparam int SPRING_DIV = 10;
  localparam int STEP_DIV   = 300;
  localparam logic [RECIP_W-1:0] SPRING_RECIP =
    RECIP_W'(((1 << RECIP_SHIFT) + SPRING_DIV - 1) / SPRING_DIV);
  localparam logic [RECIP_W-1:0] STEP_RECIP =
    RECIP_W'(((1 << RECIP_SHIFT) + STEP_DIV - 1) / STEP_DIV);

  // Reset values in whole units, scaled by the fraction width at the top
  localparam int STIFF_RST_INT  = 1;
  localparam int FRIC_RST_INT   = 100;
  localparam int TARGET_RST_INT = 1;

  // Settled when |p - target| * SETTLE_DIV < 1.0 for both the current and previous p
  localparam int SETTLE_DIV = 5000;

  localparam logic [CFG_IDX_W-1:0] CFG_STIFFNESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRICTION  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET    = 2'd2;

  localparam logic KIND_RESTART = 1'b0;
  localparam logic KIND_TICK    = 1'b1;

  typedef enum logic {
    DIV_BY_SPRING,
    DIV_BY_STEP
  } dss_div_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_K,
    S_DIV_K,
    S_WAIT_K,
    S_MUL_F,
    S_DAMP,
    S_FORCE,
    S_STEP_LO,
    S_STEP_HI,
    S_STEP_DIV,
    S_STEP_WAIT,
    S_NEXT,
    S_DONE
  } dss_state_e;

  function automatic logic [REM_W-1:0] div_divisor(dss_div_e sel);
    case (sel)
      DIV_BY_SPRING: return REM_W'(SPRING_DIV);
      default:       return REM_W'(STEP_DIV);
    endcase
  endfunction

  function automatic logic [RECIP_W-1:0] div_recip(dss_div_e sel);
    case (sel)
      DIV_BY_SPRING: return SPRING_RECIP;
      default:       return STEP_RECIP;
    endcase
  endfunction

endpackage

@@ hdl/damped_spring_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// damped_spring_step
// Damped spring advanced by Verlet steps in signed fixed point.
// ----------------------------------------------------------------------------
//  port group   dir  payload
//  s_axis_*     in   tuser: kind; tdata: time_ms, start_position
//  m_axis_*     out  tuser: settled; tdata: position
//  cfg_*        in   write only: stiffness, friction, target
//
//  A tick is computed with one shared 32x32 multiplier and a constant
//  divider that yields one quotient byte a cycle (up to three divisions of
//  9 steps); a restart skips both. One item is in flight at a time; the
//  output register lets the next item be accepted while a result waits.
//  Reset clears position and time state.
// ----------------------------------------------------------------------------
`include "damped_spring_step_assert.svh"

module damped_spring_step #(
  parameter int FRAC_BITS = dss_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [dss_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,  // time_ms, start_position
  input  logic                             s_axis_tuser_i,  // kind
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [dss_pkg::WORD_W-1:0]       m_axis_tdata_o,  // position
  output logic                             m_axis_tuser_o,  // settled
  input  logic                             cfg_we_i,
  input  logic [dss_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [dss_pkg::WORD_W-1:0]       cfg_data_i
);
  import dss_pkg::*;

  localparam logic [WORD_W-1:0] STIFF_RST  = WORD_W'(STIFF_RST_INT) << FRAC_BITS;
  localparam logic [WORD_W-1:0] FRIC_RST   = WORD_W'(FRIC_RST_INT) << FRAC_BITS;
  localparam logic [WORD_W-1:0] TARGET_RST = WORD_W'(TARGET_RST_INT) << FRAC_BITS;
  localparam int SETTLE_MAX = ((1 << FRAC_BITS) - 1) / SETTLE_DIV;
  localparam logic signed [DIFF_W-1:0] SETTLE_LIM = DIFF_W'(SETTLE_MAX);

  dss_state_e state_q, state_d;

  logic [WORD_W-1:0] stiff_q, fric_q, target_q;
  logic [WORD_W-1:0] cur_q, prev_q, last_time_q;

  logic [WORD_W-1:0]        dt_q, dmag_q, vmag_q;
  logic                     dneg_q, vneg_q, fneg_q, pass_q;
  logic signed [DIFF_W-1:0] v_q;
  logic [PROD_W-1:0]        prod_q, acc_q;
  logic [MAG_W-1:0]         m_q;

  logic              out_valid_q;
  logic [WORD_W-1:0] out_pos_q;
  logic              out_settled_q;

  // sequencer outputs
  logic     in_accept;
  logic     mul_en;
  logic     div_start;
  dss_div_e div_sel;
  logic     out_load;

  logic [WORD_W-1:0] in_time, in_start;
  assign in_time  = s_axis_tdata_i[WORD_W-1:0];
  assign in_start = s_axis_tdata_i[2*WORD_W-1:WORD_W];

  // ---------------- shared multiplier ----------------
  logic [WORD_W-1:0] mul_a, mul_b;
  always_comb begin
    case (state_q)
      S_MUL_K: begin
        mul_a = stiff_q;
        mul_b = dmag_q;
      end
      S_MUL_F: begin
        mul_a = fric_q;
        mul_b = vmag_q;
      end
      S_STEP_HI: begin
        mul_a = WORD_W'(m_q[STEP_CAP_LOG-1:WORD_W]);
        mul_b = dt_q;
      end
      default: begin
        mul_a = m_q[WORD_W-1:0];
        mul_b = dt_q;
      end
    endcase
  end

  // ---------------- constant divider ----------------
  logic [DIV_W-1:0] div_dividend, div_quot;
  logic             div_done;

  always_comb begin
    if (state_q == S_DIV_K) begin
      div_dividend = DIV_W'(prod_q >> FRAC_BITS);
    end else begin
      div_dividend = DIV_W'(acc_q) + {prod_q[STEP_CAP_LOG-1:0], {WORD_W{1'b0}}};
    end
  end

  dss_cdiv u_cdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .sel_i      (div_sel),
    .dividend_i (div_dividend),
    .quotient_o (div_quot),
    .done_o     (div_done)
  );

  // ---------------- combinational datapath terms ----------------
  logic signed [DIFF_W-1:0] d_diff, v_diff, d_neg, v_neg;
  logic [WORD_W-1:0]        dmag_in, vmag_in;
  logic [PROD_W-1:0]        spring_mag, damp_mag, fmag;
  logic [MAG_W-1:0]         step_mag;
  logic signed [NEXT_W-1:0] base_pos, am_ext, next_pos;
  logic [WORD_W-1:0]        next_sat;
  logic signed [DIFF_W-1:0] pd_diff, cd_diff;
  logic                     settled;

  always_comb begin
    d_diff  = $signed({target_q[WORD_W-1], target_q}) - $signed({cur_q[WORD_W-1], cur_q});
    v_diff  = $signed({cur_q[WORD_W-1], cur_q}) - $signed({prev_q[WORD_W-1], prev_q});
    d_neg   = -d_diff;
    v_neg   = -v_diff;
    dmag_in = d_diff[DIFF_W-1] ? d_neg[WORD_W-1:0] : d_diff[WORD_W-1:0];
    vmag_in = v_diff[DIFF_W-1] ? v_neg[WORD_W-1:0] : v_diff[WORD_W-1:0];

    spring_mag = div_quot[PROD_W-1:0];
    damp_mag   = (prod_q >> FRAC_BITS) + PROD_W'(vmag_q);
    fmag       = acc_q[PROD_W-1] ? -acc_q : acc_q;

    if (div_quot > DIV_W'(STEP_CAP)) begin
      step_mag = STEP_CAP;
    end else begin
      step_mag = div_quot[MAG_W-1:0];
    end

    base_pos = NEXT_W'($signed(cur_q)) + NEXT_W'(v_q);
    am_ext   = NEXT_W'(m_q);
    next_pos = fneg_q ? (base_pos - am_ext) : (base_pos + am_ext);
    // clamp when the upper bits are not a sign extension of bit 31
    if ((&next_pos[NEXT_W-1:WORD_W-1]) || !(|next_pos[NEXT_W-1:WORD_W-1])) begin
      next_sat = next_pos[WORD_W-1:0];
    end else if (next_pos[NEXT_W-1]) begin
      next_sat = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      next_sat = {1'b0, {(WORD_W-1){1'b1}}};
    end

    pd_diff = $signed({prev_q[WORD_W-1], prev_q}) - $signed({target_q[WORD_W-1], target_q});
    cd_diff = $signed({cur_q[WORD_W-1], cur_q}) - $signed({target_q[WORD_W-1], target_q});
    settled = (pd_diff <= SETTLE_LIM) && (pd_diff >= -SETTLE_LIM) &&
              (cd_diff <= SETTLE_LIM) && (cd_diff >= -SETTLE_LIM);
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_d   = state_q;
    in_accept = 1'b0;
    mul_en    = 1'b0;
    div_start = 1'b0;
    div_sel   = DIV_BY_STEP;
    out_load  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          in_accept = 1'b1;
          state_d   = (s_axis_tuser_i == KIND_TICK) ? S_MUL_K : S_DONE;
        end
      end
      S_MUL_K: begin
        mul_en  = 1'b1;
        state_d = S_DIV_K;
      end
      S_DIV_K: begin
        div_start = 1'b1;
        div_sel   = DIV_BY_SPRING;
        state_d   = S_WAIT_K;
      end
      S_WAIT_K: begin
        if (div_done) begin
          state_d = S_MUL_F;
        end
      end
      S_MUL_F: begin
        mul_en  = 1'b1;
        state_d = S_DAMP;
      end
      S_DAMP: begin
        state_d = S_FORCE;
      end
      S_FORCE: begin
        state_d = S_STEP_LO;
      end
      S_STEP_LO: begin
        // a capped magnitude stays capped: skip the multiply and divide
        if (m_q[STEP_CAP_LOG]) begin
          state_d = pass_q ? S_NEXT : S_STEP_LO;
        end else begin
          mul_en  = 1'b1;
          state_d = S_STEP_HI;
        end
      end
      S_STEP_HI: begin
        mul_en  = 1'b1;
        state_d = S_STEP_DIV;
      end
      S_STEP_DIV: begin
        div_start = 1'b1;
        state_d   = S_STEP_WAIT;
      end
      S_STEP_WAIT: begin
        if (div_done) begin
          state_d = pass_q ? S_NEXT : S_STEP_LO;
        end
      end
      S_NEXT: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------- configuration and spring state ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stiff_q     <= STIFF_RST;
      fric_q      <= FRIC_RST;
      target_q    <= TARGET_RST;
      cur_q       <= '0;
      prev_q      <= '0;
      last_time_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_STIFFNESS: stiff_q  <= cfg_data_i;
          CFG_FRICTION:  fric_q   <= cfg_data_i;
          CFG_TARGET:    target_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_accept) begin
        last_time_q <= in_time;
        if (s_axis_tuser_i == KIND_RESTART) begin
          cur_q  <= in_start;
          prev_q <= in_start;
        end
      end
      if (state_q == S_NEXT) begin
        prev_q <= cur_q;
        cur_q  <= next_sat;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------- working registers ----------------
  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (out_load) begin
      out_pos_q     <= cur_q;
      out_settled_q <= settled;
    end
    case (state_q)
      S_IDLE: begin
        dt_q   <= in_time - last_time_q;
        dmag_q <= dmag_in;
        vmag_q <= vmag_in;
        dneg_q <= d_diff[DIFF_W-1];
        vneg_q <= v_diff[DIFF_W-1];
        v_q    <= v_diff;
        pass_q <= 1'b0;
      end
      S_WAIT_K: begin
        acc_q <= dneg_q ? -spring_mag : spring_mag;
      end
      S_DAMP: begin
        // force = spring - damp, with damp carrying the sign of the velocity
        acc_q <= vneg_q ? (acc_q + damp_mag) : (acc_q - damp_mag);
      end
      S_FORCE: begin
        fneg_q <= acc_q[PROD_W-1];
        if (fmag >= PROD_W'(STEP_CAP)) begin
          m_q <= STEP_CAP;
        end else begin
          m_q <= fmag[MAG_W-1:0];
        end
      end
      S_STEP_LO: begin
        if (m_q[STEP_CAP_LOG]) begin
          pass_q <= 1'b1;
        end
      end
      S_STEP_HI: begin
        acc_q <= prod_q;
      end
      S_STEP_WAIT: begin
        if (div_done) begin
          m_q    <= step_mag;
          pass_q <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_pos_q;
  assign m_axis_tuser_o  = out_settled_q;

  // ---------------- assertions ----------------
  `DSS_ASSERT_NXT(a_restart_loads_both, in_accept && (s_axis_tuser_i == KIND_RESTART), cur_q == prev_q)
  `DSS_ASSERT_NXT(a_cur_held, (state_q != S_IDLE) && (state_q != S_NEXT), cur_q == $past(cur_q))
  `DSS_ASSERT_NXT(a_prev_follows, state_q == S_NEXT, prev_q == $past(cur_q))

endmodule

@@ hdl/dss_cdiv.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_cdiv
// Unsigned divide by a small constant (10 or 300), one quotient byte a cycle.
// ----------------------------------------------------------------------------
module dss_cdiv (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  dss_pkg::dss_div_e             sel_i,
  input  logic [dss_pkg::DIV_W-1:0]     dividend_i,
  output logic [dss_pkg::DIV_W-1:0]     quotient_o,
  output logic                          done_o
);
  import dss_pkg::*;

  logic [DIV_W-1:0]     num_q, num_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 done_q, done_d;
  dss_div_e             sel_q;

  logic [DIGIT_V_W-1:0] part_v;
  logic [QPROD_W-1:0]   qprod;
  logic [DIGIT_W-1:0]   qdig;
  logic [DIGIT_V_W-1:0] rem_full;

  // Reciprocal estimate is exact for part_v below divisor * 256
  always_comb begin
    part_v   = {rem_q, num_q[DIV_W-1 -: DIGIT_W]};
    qprod    = QPROD_W'(part_v) * QPROD_W'(div_recip(sel_q));
    qdig     = qprod[RECIP_SHIFT +: DIGIT_W];
    rem_full = part_v - DIGIT_V_W'(qdig) * DIGIT_V_W'(div_divisor(sel_q));
  end

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    done_d = done_q;
    if (start_i) begin
      num_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = DIV_CNT_W'(DIGITS);
      done_d = 1'b0;
    end else if (cnt_q != '0) begin
      // consume the top byte, shift the quotient byte in at the bottom
      num_d = {num_q[DIV_W-DIGIT_W-1:0], qdig};
      rem_d = rem_full[REM_W-1:0];
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (start_i) begin
      sel_q <= sel_i;
    end
  end

  assign quotient_o = num_q;
  assign done_o     = done_q;

endmodule
